>>> sv/lru_pkg.sv
// shared types, sizes and helpers for the lru age counter block
package lru_pkg;

  // sizes of the replacement state
  localparam int WAYS   = 8;
  localparam int SETS   = 64;
  localparam int AGE_W  = $clog2(WAYS);
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;

  // fixed field widths of the channel words
  localparam int IDX_W  = 6;
  localparam int WAY_W  = 3;
  localparam int MASK_W = 8;

  // operation codes
  typedef enum logic {
    OP_TOUCH  = 1'b0,
    OP_VICTIM = 1'b1
  } op_t;

  // one set's ages, one counter per way
  typedef logic [WAYS-1:0][AGE_W-1:0] row_t;

  // ages of a set after reset: each way's age is its way number
  function automatic row_t reset_row();
    row_t r;
    for (int w = 0; w < WAYS; w++) begin
      r[w] = AGE_W'(w);
    end
    return r;
  endfunction

endpackage

>>> sv/lru_if.sv
// valid/ready channel interfaces for the request and result words

interface lru_in_if;
  import lru_pkg::*;

  logic               valid;
  logic               ready;
  op_t                op;
  logic [IDX_W-1:0]   set_index;
  logic [WAY_W-1:0]   way;
  logic [MASK_W-1:0]  valid_mask;

  modport source (output valid, op, set_index, way, valid_mask, input ready);
  modport sink   (input valid, op, set_index, way, valid_mask, output ready);
endinterface

interface lru_out_if;
  import lru_pkg::*;

  logic              valid;
  logic              ready;
  logic [WAY_W-1:0]  victim_way;

  modport source (output valid, victim_way, input ready);
  modport sink   (input valid, victim_way, output ready);
endinterface

>>> sv/lru_age_counter_replacement_top.sv
// true lru replacement with per-way age counters, one age row per set in a ram
//
//   channel  dir  handshake      word
//   in_ch    in   valid/ready    op, set_index, way, valid_mask
//   out_ch   out  valid/ready    victim_way
//
// one word per cycle sustained while out_ch takes results; a taken word passes the
// update stage (ram read at the taking edge), then update/select into the output register.
// a word taken while a touch to its set is written back gets the fresh row forwarded.
// reset is synchronous; per-set valid flops make untouched rows read as
// ages 0..WAYS-1, so no clearing pass is needed.
// a stalled output holds the update stage and drops in_ch.ready.
module lru_age_counter_replacement_top (
  input  logic       clk,
  input  logic       rst_n,
  lru_in_if.sink     in_ch,
  lru_out_if.source  out_ch
);
  import lru_pkg::*;

  // age ram, one row per set, registered read
  row_t             age_mem [SETS];
  row_t             mem_q_r;
  logic [SETS-1:0]  row_vld_r;
  logic             row_vld_q_r;

  // update stage
  logic              s1_vld_r;
  op_t               s1_op_r;
  logic [IDX_W-1:0]  s1_set_r;
  logic [WAY_W-1:0]  s1_way_r;
  logic [MASK_W-1:0] s1_mask_r;
  logic              hazard_r;

  // forwarding copy of the last row written
  row_t              fwd_row_r;

  // output register
  logic              out_valid_r;
  logic [WAY_W-1:0]  out_victim_r;

  logic              s1_adv;
  logic              in_acc;
  logic              set_ok;
  logic              way_ok;
  logic              wr_en;
  row_t              cur_row;
  row_t              new_row;
  logic [WAY_W-1:0]  victim;
  logic [SET_W-1:0]  rd_addr;
  logic [SET_W-1:0]  wr_addr;

  // handshake
  assign s1_adv       = s1_vld_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_vld_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.victim_way = out_victim_r;

  assign rd_addr = in_ch.set_index[SET_W-1:0];
  assign wr_addr = s1_set_r[SET_W-1:0];
  assign set_ok  = int'(s1_set_r) < SETS;
  assign way_ok  = int'(s1_way_r) < WAYS;
  assign wr_en   = s1_adv && (s1_op_r == OP_TOUCH) && set_ok && way_ok;

  // row seen by the update stage
  always_comb begin
    if (hazard_r) begin
      cur_row = fwd_row_r;
    end else if (row_vld_q_r) begin
      cur_row = mem_q_r;
    end else begin
      cur_row = reset_row();
    end
  end

  // touch: age the younger ways, make the touched way youngest
  always_comb begin
    logic [AGE_W-1:0] age;
    age     = cur_row[s1_way_r[AGE_W-1:0]];
    new_row = cur_row;
    if (age != '0) begin
      for (int i = 0; i < WAYS; i++) begin
        if ((AGE_W'(i) != s1_way_r[AGE_W-1:0]) && (cur_row[i] <= age)) begin
          new_row[i] = cur_row[i] + AGE_W'(1);
        end
      end
      new_row[s1_way_r[AGE_W-1:0]] = '0;
    end
  end

  // victim: lowest invalid way, else oldest, lowest way on a tie
  always_comb begin
    logic             found;
    logic             is_valid;
    logic [WAY_W-1:0] inval_way;
    logic [WAY_W-1:0] best_way;
    logic [AGE_W-1:0] best_age;
    found     = 1'b0;
    inval_way = '0;
    best_way  = '0;
    best_age  = '0;
    for (int i = 0; i < WAYS; i++) begin
      is_valid = (i < MASK_W) ? s1_mask_r[i] : 1'b1;
      if (!found) begin
        if (!is_valid) begin
          found     = 1'b1;
          inval_way = WAY_W'(i);
        end else if (cur_row[i] > best_age) begin
          best_age = cur_row[i];
          best_way = WAY_W'(i);
        end
      end
    end
    if (!set_ok) begin
      victim = '0;
    end else if (found) begin
      victim = inval_way;
    end else begin
      victim = best_way;
    end
  end

  // ram write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      age_mem[wr_addr] <= new_row;
    end
    if (in_acc) begin
      mem_q_r <= age_mem[rd_addr];
    end
  end

  // per-set valid flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  // update stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      hazard_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
        hazard_r <= wr_en && (wr_addr == rd_addr);
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
        hazard_r <= 1'b0;
      end
    end
  end

  // update stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= in_ch.op;
      s1_set_r    <= in_ch.set_index;
      s1_way_r    <= in_ch.way;
      s1_mask_r   <= in_ch.valid_mask;
      row_vld_q_r <= row_vld_r[rd_addr];
    end
    if (wr_en) begin
      fwd_row_r <= new_row;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_victim_r <= (s1_op_r == OP_TOUCH) ? '0 : victim;
    end
  end

`ifndef SYNTHESIS
  // a held update stage with a stalled output blocks new words
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("word accepted while update stage is stalled");

  // forwarding flag only lives with an item in the update stage
  a_hazard_item: assert property (@(posedge clk) disable iff (!rst_n)
    hazard_r |-> s1_vld_r)
    else $error("forwarding flag set with empty update stage");

  // a touch always answers way zero
  a_touch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_op_r == OP_TOUCH)) |=> (out_ch.victim_way == '0))
    else $error("touch result is not way zero");

  // the touched way is youngest in the row written back
  a_touch_young: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (fwd_row_r[$past(s1_way_r[AGE_W-1:0])] == '0))
    else $error("touched way not youngest after update");
`endif

endmodule

>>> sim/tb_lru_age_counter_replacement_top.sv
// testbench for the lru age counter block: directed, backpressure and random traffic
`timescale 1ns / 1ps

module tb_lru_age_counter_replacement_top;
  import lru_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_WORDS  = 500;

  logic clk;
  logic rst_n;

  lru_in_if  in_ch ();
  lru_out_if out_ch ();

  lru_age_counter_replacement_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted ages, one counter per way of every set
  logic [AGE_W-1:0] age_model [SETS][WAYS];
  // victim ways still owed by the block, oldest first
  logic [WAY_W-1:0] pending_victims [$];

  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold;
  int fail_count;
  int results_checked;
  int touch_words;
  int victim_words;
  int stall_cycles;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // make the named way the youngest of its set
  function automatic void apply_touch(int unsigned set_idx, int unsigned way_sel);
    logic [AGE_W-1:0] touched_age;
    if (set_idx >= SETS || way_sel >= WAYS) return;
    touched_age = age_model[set_idx][way_sel];
    if (touched_age == '0) return;
    for (int i = 0; i < WAYS; i++) begin
      if (i != way_sel && age_model[set_idx][i] <= touched_age)
        age_model[set_idx][i] = age_model[set_idx][i] + 1'b1;
    end
    age_model[set_idx][way_sel] = '0;
  endfunction

  // lowest invalid way, else the oldest (lowest way on a tie)
  function automatic logic [WAY_W-1:0] choose_victim(int unsigned set_idx,
                                                     logic [MASK_W-1:0] mask);
    int best_way;
    logic [AGE_W-1:0] best_age;
    best_way = 0;
    best_age = '0;
    if (set_idx >= SETS) return '0;
    for (int i = 0; i < WAYS; i++) begin
      if (i < MASK_W && !mask[i]) return WAY_W'(i);
      if (age_model[set_idx][i] > best_age) begin
        best_age = age_model[set_idx][i];
        best_way = i;
      end
    end
    return WAY_W'(best_way);
  endfunction

  // offer one word, wait for it to be taken, then predict its result
  task automatic send_word(op_t op, int unsigned set_idx, int unsigned way_sel,
                           logic [MASK_W-1:0] mask);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.set_index  <= IDX_W'(set_idx);
    in_ch.way        <= WAY_W'(way_sel);
    in_ch.valid_mask <= mask;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_TOUCH) begin
      apply_touch(set_idx, way_sel);
      pending_victims.push_back('0);
      touch_words++;
    end else begin
      pending_victims.push_back(choose_victim(set_idx, mask));
      victim_words++;
    end
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_victims.size() != 0) @(posedge clk);
  endtask

  // random word shaped to keep a few sets busy so ages move far from reset
  task automatic send_random_word();
    op_t op;
    int unsigned set_idx;
    logic [MASK_W-1:0] mask;
    int pick;
    op = ($urandom_range(0, 99) < 60) ? OP_TOUCH : OP_VICTIM;
    set_idx = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 3) * 21
                                             : $urandom_range(0, SETS - 1);
    pick = $urandom_range(0, 3);
    case (pick)
      0, 1: mask = '1;
      2: mask = ~(MASK_W'(1) << $urandom_range(0, MASK_W - 1));
      default: mask = MASK_W'($urandom_range(0, 255));
    endcase
    send_word(op, set_idx, $urandom_range(0, 7), mask);
  endtask

  // victim choice on fresh sets: all valid, none valid, single holes
  task automatic test_reset_state();
    send_word(OP_VICTIM, 0, 0, 8'hFF);
    send_word(OP_VICTIM, SETS - 1, 7, 8'hFF);
    send_word(OP_VICTIM, 0, 0, 8'h00);
    send_word(OP_VICTIM, SETS - 1, 0, 8'h7F);
    send_word(OP_VICTIM, 17, 0, 8'hFE);
    send_word(OP_VICTIM, 42, 0, 8'hEF);
  endtask

  // touching the youngest way, the oldest way and the same way twice
  task automatic test_touch_ages();
    send_word(OP_TOUCH, 0, 0, 8'h00);
    send_word(OP_VICTIM, 0, 0, 8'hFF);
    send_word(OP_TOUCH, SETS - 1, 7, 8'hFF);
    send_word(OP_VICTIM, SETS - 1, 0, 8'hFF);
    send_word(OP_TOUCH, 5, 3, 8'h00);
    send_word(OP_TOUCH, 5, 3, 8'hFF);
    send_word(OP_VICTIM, 5, 0, 8'hFF);
    drain_results();
  endtask

  // back to back touches on one set exercise the row forwarding path
  task automatic test_back_to_back();
    send_word(OP_TOUCH, 9, 7, 8'h00);
    send_word(OP_TOUCH, 9, 6, 8'h00);
    send_word(OP_TOUCH, 9, 5, 8'h00);
    send_word(OP_VICTIM, 9, 0, 8'hFF);
    send_word(OP_TOUCH, 9, 4, 8'h00);
    send_word(OP_VICTIM, 9, 0, 8'hFF);
    send_word(OP_TOUCH, 9, 0, 8'h00);
    send_word(OP_VICTIM, 9, 0, 8'hFF);
    drain_results();
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_output_backpressure();
    recv_hold = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_random_word();
    drain_results();
  endtask

  // random traffic under the current idle settings
  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      send_random_word();
      // occasional pause until the block is empty
      if ($urandom_range(0, 199) == 0) drain_results();
    end
    drain_results();
  endtask

  // receiver ready, with random stalls and the long hold-off
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      out_ch.ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin : check_results
    logic [WAY_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_victims.size() == 0) begin
        $error("victim_way: unexpected word, got %0d", out_ch.victim_way);
        fail_count++;
      end else begin
        want = pending_victims.pop_front();
        results_checked++;
        if (out_ch.victim_way !== want) begin
          $error("victim_way mismatch: expected %0d, got %0d", want, out_ch.victim_way);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // test sequence
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_TOUCH;
    in_ch.set_index  = '0;
    in_ch.way        = '0;
    in_ch.valid_mask = '0;
    out_ch.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    recv_hold        = 0;
    fail_count       = 0;
    results_checked  = 0;
    touch_words      = 0;
    victim_words     = 0;
    stall_cycles     = 0;
    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < WAYS; w++)
        age_model[s][w] = AGE_W'(w);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_touch_ages();
    test_back_to_back();
    test_output_backpressure();

    send_idle_pct = 24;
    recv_idle_pct = 56;
    test_random_traffic(PHASE_WORDS);
    send_idle_pct = 56;
    recv_idle_pct = 24;
    test_random_traffic(PHASE_WORDS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(PHASE_WORDS);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d touches and %0d victim queries sent, %0d result words checked",
             touch_words, victim_words, results_checked);
    $display("summary: fresh sets, repeated touches, forwarding, a %0d cycle output hold",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
